/* hdl/sisw_pkg.sv */
package sisw_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned BYTES_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd3;

  localparam logic [ID_W-1:0] SMALL_MAX  = 32'h0000_00FF;
  localparam logic [ID_W-1:0] MEDIUM_MAX = 32'h0000_FFFF;

  function automatic logic is_small(input logic [ID_W-1:0] id);
    return id <= SMALL_MAX;
  endfunction

  function automatic logic is_medium(input logic [ID_W-1:0] id);
    return (id > SMALL_MAX) && (id <= MEDIUM_MAX);
  endfunction

endpackage

/* hdl/sisw_ram.sv */
module sisw_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/sorted_id_set_with_width_buckets_top.sv */
// Channel  | Direction | Handshake             | Payload
// command  | in        | start_i, busy_o       | func_i, uid_i, index_i
// result   | out       | done_o (one cycle)    | hit_o, value_o, status_o,
//          |           |                       | entry_count_o, packed_bytes_o
//
// Contains runs a binary search; each step reads memory (S_SRCH), then compares (S_CMP).
// Add runs the same search, then moves the entries above the insert point up, one read
// and one write per cycle, pipelined, and writes the new id in S_FIN. Get reads the entry
// at index_i; remove reads it, moves the tail down and then updates the counts. An index
// out of range answers next cycle. Reset clears the entry and bucket counts at once.
// The id memory needs no clear. The receiver cannot stall: done_o pulses once per command.
module sorted_id_set_with_width_buckets_top
  import sisw_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [ID_W-1:0]    uid_i,
  input  logic [INDEX_W-1:0] index_i,
  output logic               done_o,
  output logic               hit_o,
  output logic [ID_W-1:0]    value_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic [BYTES_W-1:0] packed_bytes_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int unsigned BW   = CW + 3 + BYTES_W;
  localparam int unsigned NW   = CW + COUNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_TAKE  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [FUNC_W-1:0] op_q, op_d;
  logic [ID_W-1:0]   uid_q, uid_d;
  logic [ID_W-1:0]   gone_q, gone_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic              found_q, found_d;
  logic [CW-1:0]     cur_q, cur_d, end_q, end_d;
  logic              up_q, up_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     dest_q, dest_d;
  logic [CW-1:0]     total_q, total_d, small_q, small_d, med_q, med_d;

  logic              emit;
  logic              hit_n;
  logic [ID_W-1:0]   value_n;
  logic [STAT_W-1:0] status_n;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ID_W-1:0]   mem_wdata, mem_rdata;

  logic              accept;
  logic              in_range;
  logic [CW-1:0]     src;
  logic [CW:0]       mid_sum;
  logic [BW-1:0]     bytes_w;
  logic [NW-1:0]     count_w;

  sisw_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = CMPW'(index_i) < CMPW'(total_q);
  assign src      = up_q ? (cur_q - 1'b1) : (cur_q + 1'b1);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    uid_d     = uid_q;
    gone_d    = gone_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    found_d   = found_q;
    cur_d     = cur_q;
    end_d     = end_q;
    up_d      = up_q;
    pend_d    = 1'b0;
    dest_d    = dest_q;
    total_d   = total_q;
    small_d   = small_q;
    med_d     = med_q;
    emit      = 1'b0;
    hit_n     = 1'b0;
    value_n   = '0;
    status_n  = STAT_DONE;
    mem_we    = 1'b0;
    mem_waddr = dest_q;
    mem_wdata = mem_rdata;
    mem_raddr = mid_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = AW'(index_i);
        if (accept) begin
          op_d  = func_i;
          uid_d = uid_i;
          if (func_i == FUNC_CONTAINS || func_i == FUNC_ADD) begin
            lo_d    = '0;
            hi_d    = total_q;
            found_d = 1'b0;
            state_d = S_SRCH;
          end else if (!in_range) begin
            emit     = 1'b1;
            status_n = STAT_RANGE;
          end else begin
            cur_d   = CW'(index_i);
            state_d = S_TAKE;
          end
        end
      end

      S_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d     = mid_sum[CW:1];
          mem_raddr = mid_d[AW-1:0];
          state_d   = S_CMP;
        end else if (op_q == FUNC_CONTAINS) begin
          emit    = 1'b1;
          hit_n   = found_q;
          state_d = S_IDLE;
        end else if (found_q) begin
          emit     = 1'b1;
          hit_n    = 1'b1;
          status_n = STAT_PRESENT;
          state_d  = S_IDLE;
        end else if (total_q >= CW'(CAPACITY)) begin
          emit     = 1'b1;
          status_n = STAT_FULL;
          state_d  = S_IDLE;
        end else begin
          // open a gap at the insert point by moving the tail up
          cur_d   = total_q;
          end_d   = lo_q;
          up_d    = 1'b1;
          state_d = S_SHIFT;
        end
      end

      S_CMP: begin
        if (mem_rdata < uid_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        if (mem_rdata == uid_q) begin
          found_d = 1'b1;
        end
        state_d = S_SRCH;
      end

      S_TAKE: begin
        if (op_q == FUNC_GET) begin
          emit    = 1'b1;
          value_n = mem_rdata;
          state_d = S_IDLE;
        end else begin
          // close the gap by moving the tail down
          gone_d  = mem_rdata;
          end_d   = total_q - 1'b1;
          up_d    = 1'b0;
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        mem_raddr = src[AW-1:0];
        mem_we    = pend_q;
        if (cur_q != end_q) begin
          pend_d = 1'b1;
          dest_d = cur_q[AW-1:0];
          cur_d  = src;
        end else if (!pend_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (op_q == FUNC_ADD) begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = uid_q;
          total_d   = total_q + 1'b1;
          if (is_small(uid_q)) begin
            small_d = small_q + 1'b1;
          end
          if (is_medium(uid_q)) begin
            med_d = med_q + 1'b1;
          end
        end else begin
          total_d = total_q - 1'b1;
          if (is_small(gone_q)) begin
            small_d = small_q - 1'b1;
          end
          if (is_medium(gone_q)) begin
            med_d = med_q - 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // 4*total - 3*small - 2*medium equals small + 2*medium + 4*large
  assign bytes_w = (BW'(total_d) << 2) - (BW'(small_d) << 1) - BW'(small_d)
                 - (BW'(med_d) << 1);
  assign count_w = NW'(total_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      total_q <= '0;
      small_q <= '0;
      med_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      total_q <= total_d;
      small_q <= small_d;
      med_q   <= med_d;
      done_o  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    uid_q   <= uid_d;
    gone_q  <= gone_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    found_q <= found_d;
    cur_q   <= cur_d;
    end_q   <= end_d;
    up_q    <= up_d;
    dest_q  <= dest_d;
    if (emit) begin
      hit_o          <= hit_n;
      value_o        <= value_n;
      status_o       <= status_n;
      entry_count_o  <= count_w[COUNT_W-1:0];
      packed_bytes_o <= bytes_w[BYTES_W-1:0];
    end
  end

  // a shift never reads the entry it is about to overwrite
  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q && cur_q != end_q) |-> (src[AW-1:0] != dest_q))
    else $error("shift read collides with pending write");

  a_bucket_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, small_q} + {1'b0, med_q}) <= {1'b0, total_q})
    else $error("bucket counts exceed entry count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_FULL) |-> (total_q == CW'(CAPACITY)))
    else $error("full status while space remains");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o || start_i))
    else $error("result transfer without a command");

endmodule
